@@ hw/rtl/lav_pkg.sv @@
// Shared constants, types and arithmetic helpers for the look-at view matrix block.
package lav_pkg;

  localparam int unsigned WordBits = 32;
  localparam int unsigned FracBits = 16;
  localparam int unsigned ColBits  = 2;

  localparam logic [WordBits-1:0] WordMax = {1'b0, {(WordBits-1){1'b1}}};
  localparam logic [WordBits-1:0] WordMin = {1'b1, {(WordBits-1){1'b0}}};

  typedef logic signed [WordBits-1:0] word_t;

  // Rounded result of a signed 66-bit sum: add half an LSB, shift down, saturate to a word.
  function automatic word_t round_sat(input logic signed [65:0] p);
    logic signed [65:0] s;
    logic signed [65:0] q;
    begin
      s = p + 66'sd32768;
      q = s >>> FracBits;
      if (q > 66'sd2147483647) begin
        round_sat = WordMax;
      end else if (q < -66'sd2147483648) begin
        round_sat = WordMin;
      end else begin
        round_sat = q[WordBits-1:0];
      end
    end
  endfunction

  // Saturate a 33-bit signed value to a word.
  function automatic word_t sat33(input logic signed [32:0] v);
    begin
      if (v > 33'sd2147483647) begin
        sat33 = WordMax;
      end else if (v < -33'sd2147483648) begin
        sat33 = WordMin;
      end else begin
        sat33 = v[WordBits-1:0];
      end
    end
  endfunction

endpackage

@@ hw/rtl/lav_norm.sv @@
// Vector normalizer: block scaling, square root and three rounded divides, fully pipelined.
module lav_norm (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  input  logic        neg_i   [3],
  input  logic [63:0] mag_i   [3],
  output logic        valid_o,
  output logic        zero_o,
  output logic signed [33:0] q_o [3]
);

  // Stage A: block scaling to 31 significant bits.
  logic        va_q;
  logic        za_q;
  logic        na_q [3];
  logic [30:0] ca_q [3];
  logic [63:0] mx;
  logic [6:0]  n;

  always_comb begin
    mx = mag_i[0];
    if (mag_i[1] > mx) mx = mag_i[1];
    if (mag_i[2] > mx) mx = mag_i[2];
    n = 7'd0;
    for (int b = 0; b < 64; b++) begin
      if (mx[b]) n = 7'(b + 1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
    end else begin
      va_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    za_q <= (mx == 64'd0);
    for (int i = 0; i < 3; i++) begin
      na_q[i] <= neg_i[i];
      if (n > 7'd31) ca_q[i] <= 31'(mag_i[i] >> (n - 7'd31));
      else           ca_q[i] <= 31'(mag_i[i] << (7'd31 - n));
    end
  end

  // Stage B: squares.
  logic        vb_q;
  logic        zb_q;
  logic        nb_q [3];
  logic [30:0] cb_q [3];
  logic [61:0] sq_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vb_q <= 1'b0;
    end else begin
      vb_q <= va_q;
    end
  end

  always_ff @(posedge clk_i) begin
    zb_q <= za_q;
    for (int i = 0; i < 3; i++) begin
      nb_q[i] <= na_q[i];
      cb_q[i] <= ca_q[i];
      sq_q[i] <= ca_q[i] * ca_q[i];
    end
  end

  // Square root: one result bit per stage over 32 stages, sum of squares below 2^64.
  localparam int unsigned SqSteps = 32;
  logic        vs_q [SqSteps+1];
  logic        zs_q [SqSteps+1];
  logic        ns_q [SqSteps+1][3];
  logic [30:0] cs_q [SqSteps+1][3];
  logic [63:0] rem_q [SqSteps+1];
  logic [31:0] root_q [SqSteps+1];

  always_comb begin
    vs_q[0]   = vb_q;
    zs_q[0]   = zb_q;
    rem_q[0]  = 64'(sq_q[0]) + 64'(sq_q[1]) + 64'(sq_q[2]);
    root_q[0] = 32'd0;
    for (int i = 0; i < 3; i++) begin
      ns_q[0][i] = nb_q[i];
      cs_q[0][i] = cb_q[i];
    end
  end

  for (genvar k = 0; k < SqSteps; k++) begin : g_sqrt
    localparam int unsigned Bit = SqSteps - 1 - k;
    logic [65:0] trial;
    logic [65:0] rem_x;
    always_comb begin
      trial = (66'(root_q[k]) << (Bit + 1)) + (66'd1 << (2 * Bit));
      rem_x = 66'(rem_q[k]);
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vs_q[k+1] <= 1'b0;
      end else begin
        vs_q[k+1] <= vs_q[k];
      end
    end
    always_ff @(posedge clk_i) begin
      zs_q[k+1] <= zs_q[k];
      for (int i = 0; i < 3; i++) begin
        ns_q[k+1][i] <= ns_q[k][i];
        cs_q[k+1][i] <= cs_q[k][i];
      end
      if (rem_x >= trial) begin
        rem_q[k+1]  <= 64'(rem_x - trial);
        root_q[k+1] <= root_q[k] | (32'd1 << Bit);
      end else begin
        rem_q[k+1]  <= rem_q[k];
        root_q[k+1] <= root_q[k];
      end
    end
  end

  // Restoring divide: (|c| << 16 + L/2) / L, quotient below 2^33, one bit per stage.
  localparam int unsigned DvSteps = 34;
  localparam int unsigned FracBitsL = lav_pkg::FracBits;
  logic        vd_q [DvSteps+1];
  logic        zd_q [DvSteps+1];
  logic        nd_q [DvSteps+1][3];
  logic [47:0] rm_q [DvSteps+1][3];
  logic [33:0] qt_q [DvSteps+1][3];
  logic [31:0] ln_q [DvSteps+1];

  always_comb begin
    vd_q[0] = vs_q[SqSteps];
    zd_q[0] = zs_q[SqSteps];
    ln_q[0] = root_q[SqSteps];
    for (int i = 0; i < 3; i++) begin
      nd_q[0][i] = ns_q[SqSteps][i];
      rm_q[0][i] = (48'(cs_q[SqSteps][i]) << FracBitsL) + 48'(root_q[SqSteps] >> 1);
      qt_q[0][i] = 34'd0;
    end
  end

  for (genvar k = 0; k < DvSteps; k++) begin : g_div
    localparam int unsigned Bit = DvSteps - 1 - k;
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vd_q[k+1] <= 1'b0;
      end else begin
        vd_q[k+1] <= vd_q[k];
      end
    end
    always_ff @(posedge clk_i) begin
      zd_q[k+1] <= zd_q[k];
      ln_q[k+1] <= ln_q[k];
      for (int i = 0; i < 3; i++) begin
        nd_q[k+1][i] <= nd_q[k][i];
        if ((82'(rm_q[k][i]) >> Bit) >= 82'(ln_q[k])) begin
          rm_q[k+1][i] <= 48'(82'(rm_q[k][i]) - (82'(ln_q[k]) << Bit));
          qt_q[k+1][i] <= qt_q[k][i] | (34'd1 << Bit);
        end else begin
          rm_q[k+1][i] <= rm_q[k][i];
          qt_q[k+1][i] <= qt_q[k][i];
        end
      end
    end
  end

  always_comb begin
    valid_o = vd_q[DvSteps];
    zero_o  = zd_q[DvSteps];
    for (int i = 0; i < 3; i++) begin
      if (zd_q[DvSteps])        q_o[i] = 34'sd0;
      else if (nd_q[DvSteps][i]) q_o[i] = -$signed(qt_q[DvSteps][i]);
      else                       q_o[i] = $signed(qt_q[DvSteps][i]);
    end
  end

endmodule

@@ hw/rtl/lav_cross.sv @@
// Cross product F x up with products registered before the subtraction.
module lav_cross (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  input  logic signed [33:0] a_i [3],
  input  logic signed [31:0] b_i [3],
  output logic        valid_o,
  output logic        neg_o [3],
  output logic [63:0] mag_o [3]
);

  logic               v1_q, v2_q;
  logic signed [65:0] p_q [6];
  logic signed [66:0] d_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= valid_i;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    p_q[0] <= a_i[1] * b_i[2];
    p_q[1] <= a_i[2] * b_i[1];
    p_q[2] <= a_i[2] * b_i[0];
    p_q[3] <= a_i[0] * b_i[2];
    p_q[4] <= a_i[0] * b_i[1];
    p_q[5] <= a_i[1] * b_i[0];
    for (int i = 0; i < 3; i++) begin
      d_q[i] <= 67'(p_q[2*i]) - 67'(p_q[2*i+1]);
    end
  end

  always_comb begin
    valid_o = v2_q;
    for (int i = 0; i < 3; i++) begin
      neg_o[i] = d_q[i][66];
      mag_o[i] = d_q[i][66] ? 64'(-d_q[i]) : 64'(d_q[i]);
    end
  end

endmodule

@@ hw/rtl/look_at_view_matrix.sv @@
// Top level of the look-at view matrix block: pipeline and column serializer.
//
// Usage: drive the eye point, target point and up hint (signed Q16.16) and
// raise start while busy is low; that edge is the input transfer.
// The block emits four column results, one per cycle, each marked by
// valid_o for exactly one cycle: column 0..2 carry (R, U, -F, 0) and
// column 3 carries the saturated translations and 1.0; last_column_o marks
// column 3 and degenerate_o is the same on all four.
// After each transfer busy stays high while the gap counter runs down; the
// single result port sends four columns per item, so a new item is taken
// only after that gap. Most of the path from the transfer edge to column 0
// (columns 1..3 follow in order) lies in the two bit-per-stage normalizers
// (a scaling stage, a squaring stage, 32 square-root and 34 divide stages
// each). Everything in between is a free-running pipeline with a valid
// bit per stage, so up to 37 items are in flight.
// Reset clears all valid bits; no item is in flight afterwards.
// The receiver cannot stall: results are shown exactly once.
module look_at_view_matrix (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic signed [31:0] eye_x_i,
  input  logic signed [31:0] eye_y_i,
  input  logic signed [31:0] eye_z_i,
  input  logic signed [31:0] target_x_i,
  input  logic signed [31:0] target_y_i,
  input  logic signed [31:0] target_z_i,
  input  logic signed [31:0] up_x_i,
  input  logic signed [31:0] up_y_i,
  input  logic signed [31:0] up_z_i,
  output logic        valid_o,
  output logic [1:0]  column_index_o,
  output logic signed [31:0] entry_0_o,
  output logic signed [31:0] entry_1_o,
  output logic signed [31:0] entry_2_o,
  output logic signed [31:0] entry_3_o,
  output logic        degenerate_o,
  output logic        last_column_o
);

  // Hold off new transfers after each one while the gap counter runs down.
  logic [1:0] gap_q;
  logic       acc;
  assign acc  = start && !busy;
  assign busy = (gap_q != 2'd0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gap_q <= 2'd0;
    end else if (acc) begin
      gap_q <= 2'd3;
    end else if (gap_q != 2'd0) begin
      gap_q <= gap_q - 2'd1;
    end
  end

  // Input stage: register fields, form exact direction differences.
  logic               v0_q;
  logic signed [31:0] eye0_q [3];
  logic signed [31:0] up0_q  [3];
  logic signed [32:0] dir0_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else begin
      v0_q <= acc;
    end
  end

  always_ff @(posedge clk_i) begin
    eye0_q[0] <= eye_x_i;
    eye0_q[1] <= eye_y_i;
    eye0_q[2] <= eye_z_i;
    up0_q[0]  <= up_x_i;
    up0_q[1]  <= up_y_i;
    up0_q[2]  <= up_z_i;
    dir0_q[0] <= 33'(target_x_i) - 33'(eye_x_i);
    dir0_q[1] <= 33'(target_y_i) - 33'(eye_y_i);
    dir0_q[2] <= 33'(target_z_i) - 33'(eye_z_i);
  end

  logic        dneg [3];
  logic [63:0] dmag [3];
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dneg[i] = dir0_q[i][32];
      dmag[i] = dir0_q[i][32] ? 64'(-dir0_q[i]) : 64'(dir0_q[i]);
    end
  end

  // Forward normalizer.
  logic               fv;
  logic               fz;
  logic signed [33:0] fq [3];

  lav_norm u_fnorm (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v0_q),
    .neg_i   (dneg),
    .mag_i   (dmag),
    .valid_o (fv),
    .zero_o  (fz),
    .q_o     (fq)
  );

  // Delay line for eye and up alongside the forward normalizer.
  localparam int unsigned NormLat = 1 + 1 + 32 + 34;
  logic signed [31:0] eyed_q [NormLat+1][3];
  logic signed [31:0] upd_q  [NormLat+1][3];
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      eyed_q[0][i] = eye0_q[i];
      upd_q[0][i]  = up0_q[i];
    end
  end
  for (genvar k = 0; k < NormLat; k++) begin : g_dly1
    always_ff @(posedge clk_i) begin
      for (int i = 0; i < 3; i++) begin
        eyed_q[k+1][i] <= eyed_q[k][i];
        upd_q[k+1][i]  <= upd_q[k][i];
      end
    end
  end

  // Block-scale up hint to 31 bits.
  logic [31:0] um [3];
  logic [31:0] umx;
  logic [5:0]  un;
  logic signed [31:0] us [3];
  logic [30:0] uc;
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      um[i] = upd_q[NormLat][i][31] ? 32'(-upd_q[NormLat][i]) : upd_q[NormLat][i];
    end
    umx = um[0];
    if (um[1] > umx) umx = um[1];
    if (um[2] > umx) umx = um[2];
    un = 6'd0;
    for (int b = 0; b < 32; b++) begin
      if (umx[b]) un = 6'(b + 1);
    end
    for (int i = 0; i < 3; i++) begin
      if (un > 6'd31) uc = 31'(um[i] >> (un - 6'd31));
      else            uc = 31'(um[i] << (6'd31 - un));
      us[i] = upd_q[NormLat][i][31] ? -$signed({1'b0, uc}) : $signed({1'b0, uc});
    end
  end

  // Register F and the scaled up hint.
  logic               v1_q, z1_q;
  logic signed [33:0] f1_q [3];
  logic signed [31:0] u1_q [3];
  logic signed [31:0] e1_q [3];
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else begin
      v1_q <= fv;
    end
  end
  always_ff @(posedge clk_i) begin
    z1_q <= fz;
    for (int i = 0; i < 3; i++) begin
      f1_q[i] <= fq[i];
      u1_q[i] <= us[i];
      e1_q[i] <= eyed_q[NormLat][i];
    end
  end

  logic        cv;
  logic        cneg [3];
  logic [63:0] cmag [3];
  lav_cross u_cross (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v1_q),
    .a_i     (f1_q),
    .b_i     (u1_q),
    .valid_o (cv),
    .neg_o   (cneg),
    .mag_o   (cmag)
  );

  logic               rv, rz;
  logic signed [33:0] rq [3];
  lav_norm u_rnorm (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (cv),
    .neg_i   (cneg),
    .mag_i   (cmag),
    .valid_o (rv),
    .zero_o  (rz),
    .q_o     (rq)
  );

  // Carry F, eye and F-degenerate past cross product and right normalizer.
  localparam int unsigned Lat2 = 2 + NormLat;
  logic               z2_q [Lat2+1];
  logic signed [33:0] f2_q [Lat2+1][3];
  logic signed [31:0] e2_q [Lat2+1][3];
  always_comb begin
    z2_q[0] = z1_q;
    for (int i = 0; i < 3; i++) begin
      f2_q[0][i] = f1_q[i];
      e2_q[0][i] = e1_q[i];
    end
  end
  for (genvar k = 0; k < Lat2; k++) begin : g_dly2
    always_ff @(posedge clk_i) begin
      z2_q[k+1] <= z2_q[k];
      for (int i = 0; i < 3; i++) begin
        f2_q[k+1][i] <= f2_q[k][i];
        e2_q[k+1][i] <= e2_q[k][i];
      end
    end
  end

  // U = R x F products; R.eye and F.eye products.
  logic               v3_q, dg3_q;
  logic signed [67:0] up3_q [6];
  logic signed [65:0] rp3_q [3];
  logic signed [65:0] fp3_q [3];
  logic signed [33:0] r3_q [3];
  logic signed [33:0] f3_q [3];
  logic signed [31:0] e3_q [3];
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else begin
      v3_q <= rv;
    end
  end
  always_ff @(posedge clk_i) begin
    dg3_q    <= rz || z2_q[Lat2];
    up3_q[0] <= rq[1] * f2_q[Lat2][2];
    up3_q[1] <= rq[2] * f2_q[Lat2][1];
    up3_q[2] <= rq[2] * f2_q[Lat2][0];
    up3_q[3] <= rq[0] * f2_q[Lat2][2];
    up3_q[4] <= rq[0] * f2_q[Lat2][1];
    up3_q[5] <= rq[1] * f2_q[Lat2][0];
    for (int i = 0; i < 3; i++) begin
      rp3_q[i] <= 66'(rq[i] * e2_q[Lat2][i]);
      fp3_q[i] <= 66'(f2_q[Lat2][i] * e2_q[Lat2][i]);
      r3_q[i]  <= rq[i];
      f3_q[i]  <= f2_q[Lat2][i];
      e3_q[i]  <= e2_q[Lat2][i];
    end
  end

  // Round U; sum translations for R and F.
  logic               v4_q, dg4_q;
  logic signed [33:0] uv4_q [3];
  logic signed [33:0] r4_q [3];
  logic signed [33:0] f4_q [3];
  logic signed [31:0] e4_q [3];
  logic signed [31:0] tr4_q, tf4_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
    end else begin
      v4_q <= v3_q;
    end
  end
  always_ff @(posedge clk_i) begin
    dg4_q <= dg3_q;
    for (int i = 0; i < 3; i++) begin
      uv4_q[i] <= 34'((68'(up3_q[2*i] - up3_q[2*i+1]) + 68'sd32768) >>> lav_pkg::FracBits);
      r4_q[i]  <= r3_q[i];
      f4_q[i]  <= f3_q[i];
      e4_q[i]  <= e3_q[i];
    end
    tr4_q <= lav_pkg::round_sat(-(rp3_q[0] + rp3_q[1] + rp3_q[2]));
    tf4_q <= lav_pkg::round_sat(fp3_q[0] + fp3_q[1] + fp3_q[2]);
  end

  // U.eye products.
  logic               v5_q, dg5_q;
  logic signed [65:0] vp5_q [3];
  logic signed [33:0] r5_q [3], f5_q [3], uv5_q [3];
  logic signed [31:0] tr5_q, tf5_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v5_q <= 1'b0;
    end else begin
      v5_q <= v4_q;
    end
  end
  always_ff @(posedge clk_i) begin
    dg5_q <= dg4_q;
    tr5_q <= tr4_q;
    tf5_q <= tf4_q;
    for (int i = 0; i < 3; i++) begin
      vp5_q[i] <= 66'(uv4_q[i] * e4_q[i]);
      r5_q[i]  <= r4_q[i];
      f5_q[i]  <= f4_q[i];
      uv5_q[i] <= uv4_q[i];
    end
  end

  // Final matrix registers, loaded on completion; serializer reads them.
  logic               dg6_q;
  logic signed [31:0] m_q [4][3];
  logic [1:0]         col_q;
  logic               run_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= 1'b0;
      col_q <= 2'd0;
    end else if (v5_q) begin
      run_q <= 1'b1;
      col_q <= 2'd0;
    end else if (run_q) begin
      col_q <= col_q + 2'd1;
      if (col_q == 2'd3) run_q <= 1'b0;
    end
  end
  always_ff @(posedge clk_i) begin
    if (v5_q) begin
      dg6_q <= dg5_q;
      for (int i = 0; i < 3; i++) begin
        m_q[i][0] <= lav_pkg::sat33(33'(r5_q[i]));
        m_q[i][1] <= lav_pkg::sat33(33'(uv5_q[i]));
        m_q[i][2] <= lav_pkg::sat33(33'(-f5_q[i]));
      end
      m_q[3][0] <= tr5_q;
      m_q[3][1] <= lav_pkg::round_sat(-(vp5_q[0] + vp5_q[1] + vp5_q[2]));
      m_q[3][2] <= tf5_q;
    end
  end

  always_comb begin
    valid_o        = run_q;
    column_index_o = col_q;
    entry_0_o      = m_q[col_q][0];
    entry_1_o      = m_q[col_q][1];
    entry_2_o      = m_q[col_q][2];
    entry_3_o      = (col_q == 2'd3) ? 32'sh0001_0000 : 32'sd0;
    degenerate_o   = dg6_q;
    last_column_o  = run_q && (col_q == 2'd3);
  end

`ifndef SYNTH
  a_col_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (run_q && col_q != 2'd3 && !v5_q) |=> (run_q && col_q == $past(col_q) + 2'd1))
    else $error("column sequence broken");
  a_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc |=> busy)
    else $error("transfer taken inside gap");
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v5_q |-> (!run_q || col_q == 2'd3))
    else $error("new matrix while columns still draining");
`endif

endmodule
